// ----- sv/dpsf_pkg.sv -----
// Shared types and constants of the duplicate point sample filter.
`default_nettype none
package dpsf_pkg;

  localparam int THR_BITS     = 20;
  localparam int NEED_BITS    = 11;
  localparam int COUNT_BITS   = 11;
  localparam int CFG_IDX_BITS = 8;
  localparam int CFG_DATA_BITS = THR_BITS;
  localparam int RES_BITS     = 15;
  localparam int OUT_BITS     = 16;

  localparam logic [THR_BITS-1:0]  THR_RESET  = 20'd328;
  localparam logic [NEED_BITS-1:0] NEED_RESET = 11'd200;

  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEEDED    = 8'd1;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  // status of the distance pipeline towards the sequencer
  typedef struct packed {
    logic busy;
    logic hit;
  } near_stat_t;

  // result beat, accepted in the lowest bit
  typedef struct packed {
    logic                  enough;
    logic [COUNT_BITS-1:0] stored_count;
    logic                  store_full;
    logic                  too_close;
    logic                  accepted;
  } res_t;

endpackage
`default_nettype wire

// ----- sv/dpsf_mem.sv -----
// Sample store: single write port, single registered read port.
`default_nettype none
module dpsf_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 72
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/dpsf_near.sv -----
// Three-stage squared distance test of the new point against one stored entry.
`default_nettype none
module dpsf_near #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [3*COORD_BITS-1:0]       point,
  input  wire logic [3*COORD_BITS-1:0]       entry,
  input  wire logic [dpsf_pkg::THR_BITS-1:0] thr,
  output dpsf_pkg::near_stat_t               stat
);

  localparam int TB    = dpsf_pkg::THR_BITS;
  localparam int DW    = COORD_BITS + 1;
  localparam int CW    = (DW > TB) ? DW : TB;
  localparam int SQ_W  = 2 * TB;
  localparam int SUM_W = SQ_W + 2;

  logic [DW-1:0]    diff [3];
  logic [CW-1:0]    mag  [3];
  logic [2:0]       far_lane;

  logic             v1, v2, v3;
  logic             far1, far2;
  logic             near3;
  logic [TB-1:0]    m1  [3];
  logic [SQ_W-1:0]  sq2 [3];
  logic [SQ_W-1:0]  thr_sq;
  logic [SUM_W-1:0] sum;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = {point[k*COORD_BITS + COORD_BITS - 1], point[k*COORD_BITS +: COORD_BITS]}
              - {entry[k*COORD_BITS + COORD_BITS - 1], entry[k*COORD_BITS +: COORD_BITS]};
      mag[k]  = diff[k][DW-1] ? CW'(DW'(-diff[k])) : CW'(diff[k]);
      far_lane[k] = mag[k] >= CW'(thr);
    end
  end

  always_comb begin
    sum = SUM_W'(sq2[0]) + SUM_W'(sq2[1]) + SUM_W'(sq2[2]);
  end

  always_ff @(posedge clk) begin
    thr_sq <= SQ_W'(thr) * SQ_W'(thr);
    for (int k = 0; k < 3; k++) begin
      m1[k]  <= mag[k][TB-1:0];
      sq2[k] <= SQ_W'(m1[k]) * SQ_W'(m1[k]);
    end
    far1  <= |far_lane;
    far2  <= far1;
    near3 <= !far2 && (sum < SUM_W'(thr_sq));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign stat.busy = v1 | v2 | v3;
  assign stat.hit  = v3 & near3;

endmodule
`default_nettype wire

// ----- sv/duplicate_point_sample_filter.sv -----
// Top level of the duplicate point sample filter: sequencer, store and distance pipeline.
// One item at a time. A clear, or a sample offered to a full or an empty store, goes
// straight to the finish state and has its result loaded into the output register from
// there. Any other sample reads the stored entries one per cycle from the store's read
// port, then waits in the drain state for the last read and the three-stage distance
// test to settle before its result is loaded. The next item is taken as soon as the
// result sits in the output register, so an unread result beat stalls the input. No
// clearing pass.
`default_nettype none
module duplicate_point_sample_filter #(
  parameter int CAPACITY   = 1024,
  parameter int COORD_BITS = 24
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // pos_x, pos_y, pos_z, zero fill
  input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]  s_tdata,
  // kind
  input  wire logic                               s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // accepted, too_close, store_full, stored_count[10:0], enough, zero fill
  output logic [dpsf_pkg::OUT_BITS-1:0]           m_tdata,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [dpsf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [dpsf_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int NB    = dpsf_pkg::NEED_BITS;
  localparam int CMP_W = (CNT_W > NB) ? CNT_W : NB;
  localparam int PW    = 3 * COORD_BITS;

  dpsf_pkg::state_t     state, state_next;
  dpsf_pkg::near_stat_t stat;
  dpsf_pkg::res_t       res, res_next;

  logic [dpsf_pkg::THR_BITS-1:0] thr;
  logic [NB-1:0]                 need;
  logic [CNT_W-1:0]              count, count_next;
  logic [PW-1:0]                 point;
  logic                          clr;
  logic                          close;
  logic [AW-1:0]                 rd_addr;
  logic                          rd_pending;
  logic [PW-1:0]                 rd_data;

  logic       accept;
  logic       rd_en;
  logic       load;
  logic       wr_en;
  logic       full;
  logic       addr_last;
  logic [CMP_W-1:0] cnt_ext;

  assign accept    = s_tvalid && s_tready;
  assign full      = count == CNT_W'(CAPACITY);
  assign addr_last = CNT_W'(rd_addr) == count - CNT_W'(1);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dpsf_pkg::S_IDLE: begin
        if (accept) begin
          if (s_tuser == dpsf_pkg::KIND_CLEAR || full || count == '0) begin
            state_next = dpsf_pkg::S_FINISH;
          end else begin
            state_next = dpsf_pkg::S_SCAN;
          end
        end
      end
      dpsf_pkg::S_SCAN: begin
        if (addr_last) begin
          state_next = dpsf_pkg::S_DRAIN;
        end
      end
      dpsf_pkg::S_DRAIN: begin
        if (!rd_pending && !stat.busy) begin
          state_next = dpsf_pkg::S_FINISH;
        end
      end
      dpsf_pkg::S_FINISH: begin
        if (load) begin
          state_next = dpsf_pkg::S_IDLE;
        end
      end
      default: state_next = dpsf_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready = 1'b0;
    rd_en    = 1'b0;
    load     = 1'b0;
    unique case (state)
      dpsf_pkg::S_IDLE:   s_tready = 1'b1;
      dpsf_pkg::S_SCAN:   rd_en    = 1'b1;
      dpsf_pkg::S_DRAIN:  ;
      dpsf_pkg::S_FINISH: load     = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // result of the item being finished
  always_comb begin
    res_next   = '0;
    count_next = count;
    wr_en      = 1'b0;
    priority if (clr) begin
      count_next = '0;
    end else if (full) begin
      res_next.store_full = 1'b1;
    end else if (close) begin
      res_next.too_close = 1'b1;
    end else begin
      res_next.accepted = 1'b1;
      count_next        = count + CNT_W'(1);
      wr_en             = load;
    end
    cnt_ext               = CMP_W'(count_next);
    res_next.stored_count = cnt_ext[dpsf_pkg::COUNT_BITS-1:0];
    res_next.enough       = cnt_ext >= CMP_W'(need);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dpsf_pkg::S_IDLE;
      count      <= '0;
      thr        <= dpsf_pkg::THR_RESET;
      need       <= dpsf_pkg::NEED_RESET;
      rd_pending <= 1'b0;
      m_tvalid   <= 1'b0;
      close      <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pending <= rd_en;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          dpsf_pkg::CFG_THRESHOLD: thr  <= cfg_data;
          dpsf_pkg::CFG_NEEDED:    need <= cfg_data[NB-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        close <= 1'b0;
      end else if (stat.hit) begin
        close <= 1'b1;
      end
      if (load) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      point   <= s_tdata[PW-1:0];
      clr     <= s_tuser;
      rd_addr <= '0;
    end else if (rd_en) begin
      rd_addr <= rd_addr + AW'(1);
    end
    if (load) begin
      res <= res_next;
    end
  end

  assign m_tdata = dpsf_pkg::OUT_BITS'(res);

  dpsf_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (PW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (point),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dpsf_near #(
    .COORD_BITS (COORD_BITS)
  ) u_near (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_pending),
    .point    (point),
    .entry    (rd_data),
    .thr      (thr),
    .stat     (stat)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("sample count beyond capacity");

  a_write_not_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("store written while full");

  a_store_grows: assert property (@(posedge clk) disable iff (rst)
    (load && res_next.accepted) |=> count == $past(count) + CNT_W'(1))
    else $error("stored sample did not advance the count");

  a_one_verdict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0({res.accepted, res.too_close, res.store_full}))
    else $error("conflicting verdict flags");

  a_read_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> $past(state) == dpsf_pkg::S_SCAN)
    else $error("store read outside scan");

endmodule
`default_nettype wire
